// ===== rtl/pfr_pkg.sv =====
// shared item types and register indexes for the page frame replacement core
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

   // configuration register indexes and widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAGE_SHIFT    = 2'd0,
      CSR_POLICY_MODE   = 2'd1,
      CSR_FRAMES_IN_USE = 2'd2
   } csr_index_type;

   // replacement policy codes
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // reset values of the registers
   localparam logic [4:0] PAGE_SHIFT_RESET    = 5'd12;
   localparam logic       POLICY_MODE_RESET   = POLICY_LRU;
   localparam logic [3:0] FRAMES_IN_USE_RESET = 4'd8;

   // one input item
   typedef struct packed {
      logic [31:0] address;
      logic        last_reference;
   } req_type;

   // one result item
   typedef struct packed {
      logic        hit;
      logic [2:0]  frame_index;
      logic        evicted_valid;
      logic [31:0] evicted_page;
      logic [31:0] fault_total;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/page_frame_replacement_core.sv =====
// top level of the page frame replacement core: controller, registers and cell chain
//
// usage
//   an item (address, last_reference) is taken at a clock edge where start is high
//   and busy is low. the page number (address >> page_shift) enters a chain of
//   FRAMES cells as a lookup wave that moves one cell per cycle; each cell adds its
//   frame (match, empty, least recent, fifo victim) to the record it hands on.
//   when the wave leaves the last cell the controller picks the frame, updates
//   every cell in that cycle and registers the result.
//   the result shows on rsp_data with rsp_valid high for exactly one cycle,
//   registered after the wave has passed every cell; the receiver cannot stall it.
//   busy stays high from the accepting edge until the result shows, so with
//   start held high a new item is taken only after the last one's result,
//   as the wave must first walk through the whole cell chain.
//   csr_we writes register csr_index (0 page_shift, 1 policy_mode, 2 frames_in_use)
//   at once; the user must make writes only while idle; the block does not check it.
//   reset clears valid bits, ranks, fifo pointer, fault count, and sets the
//   registers to page_shift 12, least recently used policy and 8 frames.
//   an item with last_reference set clears the table and count after its result.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_replacement_core
   import pfr_pkg::*;
#(
   parameter int FRAMES    = 8,
   parameter int ADDR_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);

   typedef struct packed {
      logic                 active;
      logic [ADDR_BITS-1:0] page;
      logic [CNT_W-1:0]     n;
      logic [IDX_W-1:0]     fifo_idx;
      logic                 found;
      logic [IDX_W-1:0]     hit_idx;
      logic [IDX_W-1:0]     hit_rank;
      logic                 empty_found;
      logic [IDX_W-1:0]     empty_idx;
      logic [IDX_W-1:0]     lru_idx;
      logic [IDX_W-1:0]     lru_rank;
      logic [ADDR_BITS-1:0] lru_page;
      logic [IDX_W-1:0]     fifo_rank;
      logic [ADDR_BITS-1:0] fifo_page;
   } wave_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     frame;
      logic [IDX_W-1:0]     old_rank;
      logic                 all_older;
      logic                 write_page;
      logic [ADDR_BITS-1:0] page;
      logic [CNT_W-1:0]     n;
      logic                 clear;
   } bcast_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // configuration registers
   logic [4:0] page_shift_ff;
   logic       policy_ff;
   logic [3:0] frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= PAGE_SHIFT_RESET;
         policy_ff     <= POLICY_MODE_RESET;
         frames_ff     <= FRAMES_IN_USE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_SHIFT:    page_shift_ff <= csr_wdata[4:0];
            CSR_POLICY_MODE:   policy_ff     <= csr_wdata[0];
            CSR_FRAMES_IN_USE: frames_ff     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // controller state
   state_type         state_ff, state_in;
   wave_type          launch_ff, launch_in;
   logic              last_ff, last_in;
   logic [IDX_W-1:0]  oldest_ff, oldest_in;
   logic [31:0]       fault_ff, fault_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bcast_type         bcast;
   wave_type          tail;
   wave_type          chain [FRAMES+1];

   logic                 accept;
   logic [CNT_W-1:0]     n_now;
   logic [ADDR_BITS-1:0] addr_ext;

   assign accept   = start && (state_ff == ST_IDLE);
   assign addr_ext = ADDR_BITS'(req_data.address);

   // clamp the frame count into 1 .. FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         n_now = CNT_W'(1);
      end else if (32'(frames_ff) > 32'(FRAMES)) begin
         n_now = CNT_W'(FRAMES);
      end else begin
         n_now = CNT_W'(frames_ff);
      end
   end

   // next state, launch record, victim choice and result
   always_comb begin
      logic [IDX_W-1:0]     f;
      logic [ADDR_BITS-1:0] ev_page;
      logic                 ev_valid;
      state_in     = state_ff;
      launch_in    = '0;
      last_in      = last_ff;
      oldest_in    = oldest_ff;
      fault_in     = fault_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      bcast        = '0;
      f            = tail.hit_idx;
      ev_page      = '0;
      ev_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               launch_in.active   = 1'b1;
               launch_in.page     = addr_ext >> page_shift_ff;
               launch_in.n        = n_now;
               launch_in.fifo_idx = (CNT_W'(oldest_ff) < n_now) ? oldest_ff : '0;
               last_in            = req_data.last_reference;
               state_in           = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail.active) begin
               bcast.en        = 1'b1;
               bcast.page      = tail.page;
               bcast.n         = tail.n;
               bcast.clear     = last_ff;
               if (tail.found) begin
                  f              = tail.hit_idx;
                  bcast.old_rank = tail.hit_rank;
               end else begin
                  bcast.write_page = 1'b1;
                  if (fault_ff != 32'hFFFF_FFFF) begin
                     fault_in = fault_ff + 32'd1;
                  end
                  if (tail.empty_found) begin
                     f               = tail.empty_idx;
                     bcast.all_older = 1'b1;
                  end else if (policy_ff == POLICY_FIFO) begin
                     f              = tail.fifo_idx;
                     bcast.old_rank = tail.fifo_rank;
                     ev_valid       = 1'b1;
                     ev_page        = tail.fifo_page;
                     if ((CNT_W'(f) + CNT_W'(1)) < tail.n) begin
                        oldest_in = IDX_W'(CNT_W'(f) + CNT_W'(1));
                     end else begin
                        oldest_in = '0;
                     end
                  end else begin
                     f              = tail.lru_idx;
                     bcast.old_rank = tail.lru_rank;
                     ev_valid       = 1'b1;
                     ev_page        = tail.lru_page;
                  end
               end
               bcast.frame          = f;
               rsp_in.hit           = tail.found;
               rsp_in.frame_index   = 3'(f);
               rsp_in.evicted_valid = ev_valid;
               rsp_in.evicted_page  = 32'(ev_page);
               rsp_in.fault_total   = fault_in;
               rsp_valid_in         = 1'b1;
               if (last_ff) begin
                  fault_in  = '0;
                  oldest_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         launch_ff.active <= 1'b0;
         oldest_ff       <= '0;
         fault_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         oldest_ff    <= oldest_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   // cell chain
   assign chain[0] = launch_ff;
   assign tail     = chain[FRAMES];

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      pfr_cell #(
         .IDX        (i),
         .FRAMES     (FRAMES),
         .ADDR_BITS  (ADDR_BITS),
         .wave_type  (wave_type),
         .bcast_type (bcast_type)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wave_in  (chain[i]),
         .wave_out (chain[i+1]),
         .bcast    (bcast)
      );
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/pfr_cell.sv =====
// one frame cell: holds a page, valid bit and recency rank, passes the lookup wave on
`timescale 1ns / 1ps
`default_nettype none

module pfr_cell #(
   parameter int  IDX       = 0,
   parameter int  FRAMES    = 8,
   parameter int  ADDR_BITS = 32,
   parameter type wave_type = logic,
   parameter type bcast_type = logic
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire wave_type  wave_in,
   output wave_type       wave_out,
   input  wire bcast_type bcast
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(IDX);
   localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);

   logic [ADDR_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic [IDX_W-1:0]     rank_ff;
   logic [ADDR_BITS-1:0] page_in;
   logic                 valid_in;
   logic [IDX_W-1:0]     rank_in;
   wave_type             carry_ff;
   wave_type             carry_in;
   logic                 scan_in_use;
   logic                 upd_in_use;

   assign scan_in_use = CNT_W'(IDX) < wave_in.n;
   assign upd_in_use  = CNT_W'(IDX) < bcast.n;

   // fold this frame into the passing lookup record
   always_comb begin
      carry_in = wave_in;
      if (wave_in.active && scan_in_use) begin
         if (!wave_in.found && valid_ff && (page_ff == wave_in.page)) begin
            carry_in.found    = 1'b1;
            carry_in.hit_idx  = MY_IDX;
            carry_in.hit_rank = rank_ff;
         end
         if (!wave_in.empty_found && !valid_ff) begin
            carry_in.empty_found = 1'b1;
            carry_in.empty_idx   = MY_IDX;
         end
         if ((IDX == 0) || (rank_ff > wave_in.lru_rank)) begin
            carry_in.lru_idx  = MY_IDX;
            carry_in.lru_rank = rank_ff;
            carry_in.lru_page = page_ff;
         end
         if (wave_in.fifo_idx == MY_IDX) begin
            carry_in.fifo_rank = rank_ff;
            carry_in.fifo_page = page_ff;
         end
      end
   end

   // recency update, fill and end-of-run clear
   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (bcast.en) begin
         if (bcast.frame == MY_IDX) begin
            rank_in = '0;
            if (bcast.write_page) begin
               page_in  = bcast.page;
               valid_in = 1'b1;
            end
         end else if (upd_in_use && valid_ff && (bcast.all_older || (rank_ff < bcast.old_rank))
                      && (rank_ff != RANK_MAX)) begin
            rank_in = rank_ff + IDX_W'(1);
         end
         if (bcast.clear) begin
            valid_in = 1'b0;
            rank_in  = '0;
         end
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      page_ff <= page_in;
   end

   // wave register toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.active <= 1'b0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   assign wave_out = carry_ff;

endmodule

`default_nettype wire

// ===== rtl/pfr_checker.sv =====
// port-level checks of the page frame replacement core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pfr_checker
   import pfr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted item");

   // the result shows only once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // one item gives one strobe
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> !rsp_data.evicted_valid)
      else $error("eviction reported on a hit");

   // no eviction means a zero evicted page
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.evicted_valid |-> (rsp_data.evicted_page == 32'd0))
      else $error("evicted page not zero without eviction");

endmodule

bind page_frame_replacement_core pfr_checker u_pfr_checker (.*);

`default_nettype wire
